// ----- rtl/pttt_pkg.sv -----
// Shared types and codes for the periodic task timer table.
package pttt_pkg;

   localparam logic FUNC_REGISTER = 1'b0;
   localparam logic FUNC_TICK     = 1'b1;

   localparam logic KIND_ACK  = 1'b0;
   localparam logic KIND_FIRE = 1'b1;

   typedef struct packed {
      logic        func;
      logic [7:0]  task_id;
      logic [15:0] period;
      logic [31:0] task_data;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic        accepted;
      logic [3:0]  slot;
      logic [7:0]  fired_task;
      logic [31:0] fired_data;
      logic        last;
   } rsp_type;

endpackage

// ----- rtl/periodic_task_timer_table_core.sv -----
// Periodic task timer table: slot registration and tick scan over a slot memory.
//
//  channel | direction | handshake                | payload
//  req     | in        | req_valid / req_stall    | req_data  (pttt_pkg::req_type)
//  rsp     | out       | rsp_valid / rsp_stall    | rsp_data  (pttt_pkg::rsp_type)
//
// Register: acknowledgement loaded into the output register on the accepting edge.
// Tick: req_stall high until the scan is done: one registered slot read per cycle, then the
// read stage drains, the empty stage is seen, and the flush state sends any held result.
// A fire result is held back one slot so its last flag is known; a stalled output
// register pauses the scan or flush only when a held result must move out.
// Synchronous active-high reset empties the table; slot storage is not cleared.
module periodic_task_timer_table_core #(
   parameter int SLOTS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pttt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pttt_pkg::rsp_type rsp_data
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   // slot memory
   logic [15:0] mem_period  [SLOTS];
   logic [15:0] mem_counter [SLOTS];
   logic [7:0]  mem_task    [SLOTS];
   logic [31:0] mem_data    [SLOTS];

   state_type         state_ff;
   logic [CNT_W-1:0]  used_ff;
   logic [CNT_W-1:0]  scan_idx_ff;
   logic              stage_vld_ff;
   logic [IDX_W-1:0]  stage_idx_ff;
   logic [15:0]       rd_period_ff;
   logic [15:0]       rd_counter_ff;
   logic [7:0]        rd_task_ff;
   logic [31:0]       rd_data_ff;
   logic              pend_vld_ff;
   logic [IDX_W-1:0]  pend_idx_ff;
   logic [7:0]        pend_task_ff;
   logic [31:0]       pend_data_ff;
   logic              rsp_valid_ff;
   pttt_pkg::rsp_type rsp_data_ff;

   logic              out_free;
   logic              req_take;
   logic              reg_take;
   logic              room;
   logic              fire;
   logic              need_push;
   logic              advance;
   logic              issue_rd;
   logic              ctr_we;
   logic [IDX_W-1:0]  ctr_waddr;
   logic [15:0]       ctr_wdata;
   logic [IDX_W+3:0]  pend_ext;
   logic [CNT_W+3:0]  used_ext;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign req_take  = req_valid && !req_stall;
   assign reg_take  = req_take && (req_data.func == pttt_pkg::FUNC_REGISTER);
   assign room      = used_ff < SLOTS_CNT;

   // scan pipeline: stage holds the slot read on the previous cycle
   assign fire      = stage_vld_ff && (rd_counter_ff == 16'd0);
   assign need_push = fire && pend_vld_ff;
   assign advance   = (state_ff == ST_SCAN) && (!need_push || out_free);
   assign issue_rd  = advance && (scan_idx_ff < used_ff);

   assign pend_ext = (IDX_W + 4)'(pend_idx_ff);
   assign used_ext = (CNT_W + 4)'(used_ff);

   // single counter write port: registration load or scan update
   always_comb begin
      ctr_we    = 1'b0;
      ctr_waddr = stage_idx_ff;
      ctr_wdata = fire ? rd_period_ff : (rd_counter_ff - 16'd1);
      if (reg_take && room) begin
         ctr_we    = 1'b1;
         ctr_waddr = used_ff[IDX_W-1:0];
         ctr_wdata = req_data.period;
      end else if (advance && stage_vld_ff) begin
         ctr_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reg_take && room) begin
         mem_period[used_ff[IDX_W-1:0]] <= req_data.period;
         mem_task[used_ff[IDX_W-1:0]]   <= req_data.task_id;
         mem_data[used_ff[IDX_W-1:0]]   <= req_data.task_data;
      end
      if (ctr_we) begin
         mem_counter[ctr_waddr] <= ctr_wdata;
      end
      if (issue_rd) begin
         rd_period_ff  <= mem_period[scan_idx_ff[IDX_W-1:0]];
         rd_counter_ff <= mem_counter[scan_idx_ff[IDX_W-1:0]];
         rd_task_ff    <= mem_task[scan_idx_ff[IDX_W-1:0]];
         rd_data_ff    <= mem_data[scan_idx_ff[IDX_W-1:0]];
      end
   end

   // sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         scan_idx_ff  <= '0;
         stage_vld_ff <= 1'b0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  if (req_data.func == pttt_pkg::FUNC_REGISTER) begin
                     rsp_valid_ff            <= 1'b1;
                     rsp_data_ff.kind        <= pttt_pkg::KIND_ACK;
                     rsp_data_ff.accepted    <= room;
                     rsp_data_ff.slot        <= room ? used_ext[3:0] : 4'd0;
                     rsp_data_ff.fired_task  <= 8'd0;
                     rsp_data_ff.fired_data  <= 32'd0;
                     rsp_data_ff.last        <= 1'b1;
                     if (room) begin
                        used_ff <= used_ff + CNT_W'(1);
                     end
                  end else begin
                     state_ff     <= ST_SCAN;
                     scan_idx_ff  <= '0;
                     stage_vld_ff <= 1'b0;
                     pend_vld_ff  <= 1'b0;
                  end
               end
            end
            ST_SCAN: begin
               if (advance) begin
                  if (need_push) begin
                     // a later slot fired, so the held one is not the last
                     rsp_valid_ff           <= 1'b1;
                     rsp_data_ff.kind       <= pttt_pkg::KIND_FIRE;
                     rsp_data_ff.accepted   <= 1'b0;
                     rsp_data_ff.slot       <= pend_ext[3:0];
                     rsp_data_ff.fired_task <= pend_task_ff;
                     rsp_data_ff.fired_data <= pend_data_ff;
                     rsp_data_ff.last       <= 1'b0;
                  end
                  if (fire) begin
                     pend_vld_ff  <= 1'b1;
                     pend_idx_ff  <= stage_idx_ff;
                     pend_task_ff <= rd_task_ff;
                     pend_data_ff <= rd_data_ff;
                  end
                  if (issue_rd) begin
                     stage_vld_ff <= 1'b1;
                     stage_idx_ff <= scan_idx_ff[IDX_W-1:0];
                     scan_idx_ff  <= scan_idx_ff + CNT_W'(1);
                  end else begin
                     stage_vld_ff <= 1'b0;
                     if (!stage_vld_ff) begin
                        state_ff <= ST_FLUSH;
                     end
                  end
               end
            end
            ST_FLUSH: begin
               if (!pend_vld_ff) begin
                  state_ff <= ST_IDLE;
               end else if (out_free) begin
                  rsp_valid_ff           <= 1'b1;
                  rsp_data_ff.kind       <= pttt_pkg::KIND_FIRE;
                  rsp_data_ff.accepted   <= 1'b0;
                  rsp_data_ff.slot       <= pend_ext[3:0];
                  rsp_data_ff.fired_task <= pend_task_ff;
                  rsp_data_ff.fired_data <= pend_data_ff;
                  rsp_data_ff.last       <= 1'b1;
                  pend_vld_ff            <= 1'b0;
                  state_ff               <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/pttt_checker.sv -----
// Port-level checks for the periodic task timer table, bound to periodic_task_timer_table_core.
module pttt_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input pttt_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input pttt_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_ack_now: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.func == pttt_pkg::FUNC_REGISTER |=>
      rsp_valid && rsp_data.kind == pttt_pkg::KIND_ACK)
      else $error("registration not acknowledged on next cycle");

   a_ack_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == pttt_pkg::KIND_ACK |-> rsp_data.last &&
      rsp_data.fired_task == 8'd0 && rsp_data.fired_data == 32'd0)
      else $error("acknowledgement fields malformed");

   a_fire_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == pttt_pkg::KIND_FIRE |-> !rsp_data.accepted)
      else $error("fire result marked accepted");

   a_blocked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request taken while result stalled");

endmodule

bind periodic_task_timer_table_core pttt_checker u_pttt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ----- bench/tb_periodic_task_timer_table_core.sv -----
// Self-checking bench for the periodic task timer table: registration, tick scan, fire order.
module tb_periodic_task_timer_table_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOT_COUNT     = 16;
   localparam int RANDOM_ITEMS   = 305;
   localparam int QUIET_TAIL     = 40;    // last transactions go without any pauses
   localparam int DRAIN_AT       = 150;   // random transaction that waits for a drained pipe
   localparam int TAIL_CYCLES    = 50;    // longer than a full 16-slot scan
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct {
      pttt_pkg::req_type payload;
      bit                drain_first;   // hold off until every awaited fire/ack has arrived
   } stim_entry_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   pttt_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   pttt_pkg::rsp_type rsp_data;

   periodic_task_timer_table_core #(
      .SLOTS(SLOT_COUNT)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // ---------------------------------------------------------------------
   // Shadow copy of the slot table, advanced once per accepted request.
   // ---------------------------------------------------------------------
   int          occupancy;
   logic [15:0] reload_val  [SLOT_COUNT];
   logic [15:0] count_down  [SLOT_COUNT];
   logic [7:0]  owner_task  [SLOT_COUNT];
   logic [31:0] payload_word[SLOT_COUNT];

   pttt_pkg::rsp_type awaited_rsp[$];
   stim_entry_type    stim_q[$];

   // bookkeeping for the summary and the watchdog
   int  slots_added, refusals, ticks_seen, fires_checked, silent_ticks;
   int  mismatches;
   int  cycle_no;
   int  idle_cycles;
   bit  timed_out;
   bit  req_taken;   // request accepted at the last rising edge
   int  req_gap, rsp_gap;

   // Work out what one request does to the table and queue the results it causes.
   task automatic forecast_timer_results(input pttt_pkg::req_type item);
      pttt_pkg::rsp_type r;
      pttt_pkg::rsp_type held;
      bit                have_held;
      r         = '0;
      held      = '0;
      have_held = 1'b0;
      if (item.func == pttt_pkg::FUNC_REGISTER) begin
         r.kind = pttt_pkg::KIND_ACK;
         r.last = 1'b1;
         if (occupancy < SLOT_COUNT) begin
            owner_task[occupancy]   = item.task_id;
            reload_val[occupancy]   = item.period;
            count_down[occupancy]   = item.period;
            payload_word[occupancy] = item.task_data;
            r.accepted = 1'b1;
            r.slot     = occupancy[3:0];
            occupancy++;
            slots_added++;
         end else begin
            // table full: refused, slot reads back as 0, table untouched
            refusals++;
         end
         awaited_rsp.push_back(r);
      end else begin
         ticks_seen++;
         // scan in registration order; a fire is held back one slot so the
         // final one can carry the last flag
         for (int i = 0; i < occupancy; i++) begin
            if (count_down[i] == 16'd0) begin
               count_down[i] = reload_val[i];
               if (have_held) awaited_rsp.push_back(held);
               held            = '0;
               held.kind       = pttt_pkg::KIND_FIRE;
               held.slot       = i[3:0];
               held.fired_task = owner_task[i];
               held.fired_data = payload_word[i];
               have_held       = 1'b1;
            end else begin
               count_down[i] = count_down[i] - 16'd1;
            end
         end
         if (have_held) begin
            held.last = 1'b1;
            awaited_rsp.push_back(held);
         end else begin
            silent_ticks++;   // empty table or nothing due: no transaction out
         end
      end
   endtask

   task automatic queue_request(input logic func, input logic [7:0] tid,
                                input logic [15:0] per, input logic [31:0] word,
                                input bit drain);
      stim_entry_type e;
      e.payload.func      = func;
      e.payload.task_id   = tid;
      e.payload.period    = per;
      e.payload.task_data = word;
      e.drain_first       = drain;
      stim_q.push_back(e);
   endtask

   // Pauses are off near the end and during one stretch in every four.
   function automatic bit pauses_enabled();
      return stim_q.size() >= QUIET_TAIL && ((cycle_no / 128) % 4) != 3;
   endfunction

   // ---------------------------------------------------------------------
   // Request driver: falling edge, holds a stalled transaction unchanged.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      stim_entry_type head;
      if (!reset && (!req_valid || req_taken)) begin
         if (req_gap > 0) begin
            req_gap   <= req_gap - 1;
            req_valid <= 1'b0;
         end else if (stim_q.size() == 0 ||
                      (stim_q[0].drain_first && awaited_rsp.size() != 0)) begin
            req_valid <= 1'b0;
         end else if (pauses_enabled() && $urandom_range(0, 7) == 0) begin
            req_gap   <= $urandom_range(0, 9);   // burst of idle cycles
            req_valid <= 1'b0;
         end else begin
            head = stim_q.pop_front();
            req_data  <= head.payload;
            req_valid <= 1'b1;
         end
      end
   end

   // Result-side back-pressure, also in bursts.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap   <= rsp_gap - 1;
         rsp_stall <= 1'b1;
      end else if (pauses_enabled() && $urandom_range(0, 5) == 0) begin
         rsp_gap   <= $urandom_range(0, 9);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: rising edge. Predicts on accepted requests, checks accepted
   // results against the oldest awaited one, and runs the watchdog.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      pttt_pkg::rsp_type want;
      pttt_pkg::rsp_type got;
      bit                rsp_taken;
      req_taken = 1'b0;
      rsp_taken = 1'b0;
      if (!reset) begin
         cycle_no++;
         if (req_valid && !req_stall) begin
            req_taken = 1'b1;
            forecast_timer_results(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            rsp_taken = 1'b1;
            got       = rsp_data;
            if (awaited_rsp.size() == 0) begin
               $error("unexpected result transaction: kind %0d slot %0d", got.kind, got.slot);
               mismatches++;
            end else begin
               want = awaited_rsp.pop_front();
               if (want.kind == pttt_pkg::KIND_FIRE) fires_checked++;
               if (got.kind !== want.kind) begin
                  $error("kind: expected %0d, got %0d", want.kind, got.kind);
                  mismatches++;
               end
               if (got.accepted !== want.accepted) begin
                  $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
                  mismatches++;
               end
               if (got.slot !== want.slot) begin
                  $error("slot: expected %0d, got %0d", want.slot, got.slot);
                  mismatches++;
               end
               if (got.fired_task !== want.fired_task) begin
                  $error("fired_task: expected %0h, got %0h", want.fired_task, got.fired_task);
                  mismatches++;
               end
               if (got.fired_data !== want.fired_data) begin
                  $error("fired_data: expected %0h, got %0h", want.fired_data, got.fired_data);
                  mismatches++;
               end
               if (got.last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, got.last);
                  mismatches++;
               end
            end
         end
         // watchdog: cycles in a row with no transaction on either side
         if (req_taken || rsp_taken) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= WATCHDOG_LIMIT) timed_out = 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus, reset and end of run.
   // ---------------------------------------------------------------------
   initial begin
      int n;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      rsp_stall     = 1'b0;
      req_taken     = 1'b0;
      req_gap       = 0;
      rsp_gap       = 0;
      occupancy     = 0;
      slots_added   = 0;
      refusals      = 0;
      ticks_seen    = 0;
      fires_checked = 0;
      silent_ticks  = 0;
      mismatches    = 0;
      cycle_no      = 0;
      idle_cycles   = 0;
      timed_out     = 1'b0;

      // Directed: tick on an empty table, then fill the table with ticks in
      // between, field extremes in the first slots.
      queue_request(pttt_pkg::FUNC_TICK, 8'h00, 16'h0000, 32'h0000_0000, 1'b0);
      queue_request(pttt_pkg::FUNC_REGISTER, 8'h00, 16'h0001, 32'h0000_0000, 1'b0);
      // counter 1->0, silent
      queue_request(pttt_pkg::FUNC_TICK, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
      // slot 0 fires
      queue_request(pttt_pkg::FUNC_TICK, 8'h00, 16'h0000, 32'h0000_0000, 1'b0);
      queue_request(pttt_pkg::FUNC_REGISTER, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
      // fires every tick
      queue_request(pttt_pkg::FUNC_REGISTER, 8'($urandom), 16'h0000, $urandom, 1'b0);
      queue_request(pttt_pkg::FUNC_TICK, 8'($urandom), 16'($urandom), $urandom, 1'b0);
      for (n = 3; n < SLOT_COUNT; n++) begin
         if (n == SLOT_COUNT - 1) begin
            queue_request(pttt_pkg::FUNC_REGISTER, 8'($urandom),
                          16'($urandom_range(7, 300)), $urandom, 1'b0);
         end else begin
            queue_request(pttt_pkg::FUNC_REGISTER, 8'($urandom),
                          16'($urandom_range(0, 6)), $urandom, 1'b0);
         end
         if (n % 4 == 0) begin
            queue_request(pttt_pkg::FUNC_TICK, 8'($urandom), 16'($urandom), $urandom, 1'b0);
         end
      end
      // table full: refused
      queue_request(pttt_pkg::FUNC_REGISTER, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
      queue_request(pttt_pkg::FUNC_TICK, 8'h00, 16'h0000, 32'h0000_0000, 1'b0);

      // Random: mostly ticks over the full table, some refused registrations.
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         queue_request(($urandom_range(0, 99) < 85) ? pttt_pkg::FUNC_TICK
                                                    : pttt_pkg::FUNC_REGISTER,
                       8'($urandom), 16'($urandom), $urandom, n == DRAIN_AT);
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // all requests in, then all results out
      while (!timed_out && (stim_q.size() != 0 || req_valid || awaited_rsp.size() != 0))
         @(posedge clock);
      // let a trailing scan finish so stray results get caught
      n = 0;
      while (!timed_out && n < TAIL_CYCLES) begin
         @(posedge clock);
         n++;
      end

      if (timed_out) begin
         $error("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
         mismatches++;
      end
      if (awaited_rsp.size() != 0) begin
         $error("%0d result transactions never arrived", awaited_rsp.size());
         mismatches++;
      end

      $display("Run: %0d slots added, %0d registrations refused, %0d ticks (%0d silent)",
               slots_added, refusals, ticks_seen, silent_ticks);
      $display("Run: %0d fire results checked, %0d mismatches", fires_checked, mismatches);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
